FILE: rtl/nfsa_pkg.sv
package nfsa_pkg;

  localparam int WORD_W = 32;
  localparam int BIT_W  = 5;
  localparam int IDXW   = 12;
  localparam int GRANTW = 11;
  localparam int STATW  = 2;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [STATW-1:0] ST_OK    = 2'd0;
  localparam logic [STATW-1:0] ST_FULL  = 2'd1;
  localparam logic [STATW-1:0] ST_RANGE = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_ALLOC_WR,
    S_FREE_RD,
    S_FREE_WR,
    S_DONE
  } nfsa_state_t;

  typedef struct packed {
    logic accept;
    logic scan;
    logic alloc_wr;
    logic free_rd;
    logic free_wr;
    logic load_out;
  } nfsa_ctl_t;

  typedef struct packed {
    logic req_free;
    logic req_in_range;
    logic hit;
    logic exhausted;
    logic out_free;
  } nfsa_sts_t;

endpackage

FILE: rtl/next_fit_slot_allocator.sv
// Next-fit slot allocator over a pool of SLOTS slots (4 to 2048), one used bit
// per slot held in a 32-bit-wide RAM of ceil(SLOTS/32) rows, each row with a
// valid flop so reset frees the whole pool. cmd 0 allocates the first free
// slot at or after the cursor, wrapping once, and returns it with status ok,
// or status full with slot 0; cmd 1 frees slot_index, or returns status range
// when slot_index >= SLOTS. One transaction is in work at a time. An allocate
// scans one RAM row per cycle through the single read port; a free reads its
// row and writes it back, and an out-of-range free touches no row. A finished
// result sits in an output register, so the next transaction is taken while
// it waits.
module next_fit_slot_allocator
  import nfsa_pkg::*;
#(
  parameter int SLOTS = 2048
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              cmd,
  input  logic [IDXW-1:0]   slot_index,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [STATW-1:0]  status,
  output logic [GRANTW-1:0] granted_slot
);

  nfsa_ctl_t ctl;
  nfsa_sts_t sts;

  nfsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  nfsa_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .sts          (sts),
    .cmd          (cmd),
    .slot_index   (slot_index),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .granted_slot (granted_slot)
  );

endmodule

FILE: rtl/nfsa_ram.sv
module nfsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/nfsa_ctrl.sv
module nfsa_ctrl
  import nfsa_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  nfsa_sts_t sts,
  output nfsa_ctl_t ctl
);

  nfsa_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.accept = 1'b1;
          if (!sts.req_free) begin
            state_next = S_SCAN;
          end else if (sts.req_in_range) begin
            state_next = S_FREE_RD;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_SCAN: begin
        ctl.scan = 1'b1;
        if (sts.hit) begin
          state_next = S_ALLOC_WR;
        end else if (sts.exhausted) begin
          state_next = S_DONE;
        end
      end
      S_ALLOC_WR: begin
        ctl.alloc_wr = 1'b1;
        state_next   = S_DONE;
      end
      S_FREE_RD: begin
        ctl.free_rd = 1'b1;
        state_next  = S_FREE_WR;
      end
      S_FREE_WR: begin
        ctl.free_wr = 1'b1;
        state_next  = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          ctl.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/nfsa_dp.sv
module nfsa_dp
  import nfsa_pkg::*;
#(
  parameter int SLOTS = 2048
) (
  input  logic              clk,
  input  logic              rst,
  input  nfsa_ctl_t         ctl,
  output nfsa_sts_t         sts,
  input  logic              cmd,
  input  logic [IDXW-1:0]   slot_index,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [STATW-1:0]  status,
  output logic [GRANTW-1:0] granted_slot
);

  localparam int NW     = (SLOTS + WORD_W - 1) / WORD_W;
  localparam int AW     = (NW > 1) ? $clog2(NW) : 1;
  localparam int XW     = AW + BIT_W;
  localparam int IW     = $clog2(SLOTS);
  localparam int KW     = $clog2(NW + 2);
  localparam int LAST_N = SLOTS - (NW - 1) * WORD_W;
  localparam int CW     = IDXW + 1;

  logic [IW-1:0]     cursor;
  logic [IW-1:0]     req_idx;
  logic [BIT_W-1:0]  start_off;
  logic [AW-1:0]     rd_addr;
  logic [KW-1:0]     iss_k;
  logic              chk_vld;
  logic [AW-1:0]     chk_addr;
  logic [KW-1:0]     chk_k;
  logic [NW-1:0]     row_valid;
  logic [AW-1:0]     hit_addr;
  logic [WORD_W-1:0] hit_word;
  logic [IW-1:0]     found_idx;
  logic [STATW-1:0]  res_status;
  logic [GRANTW-1:0] res_grant;

  logic [XW-1:0]     cursor_x;
  logic [XW-1:0]     idx_x;
  logic [AW-1:0]     free_word;
  logic [BIT_W-1:0]  free_bit;
  logic              in_range;
  logic              issue_en;
  logic              ram_we;
  logic              ram_re;
  logic [AW-1:0]     ram_waddr;
  logic [AW-1:0]     ram_raddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;
  logic [AW-1:0]     eff_addr;
  logic [WORD_W-1:0] word_eff;
  logic [WORD_W-1:0] free_bits;
  logic              hit_any;
  logic [BIT_W-1:0]  hit_bit;
  logic [XW-1:0]     hit_idx_x;
  logic [IW-1:0]     hit_idx;
  logic              hit;

  assign cursor_x  = XW'(cursor);
  assign idx_x     = XW'(req_idx);
  assign free_word = idx_x[XW-1:BIT_W];
  assign free_bit  = idx_x[BIT_W-1:0];
  assign in_range  = CW'(slot_index) < CW'(SLOTS);

  assign issue_en  = ctl.scan && (iss_k <= KW'(NW));
  assign ram_re    = issue_en || ctl.free_rd;
  assign ram_raddr = ctl.free_rd ? free_word : rd_addr;
  assign ram_we    = ctl.alloc_wr || ctl.free_wr;
  assign ram_waddr = ctl.alloc_wr ? hit_addr : free_word;
  assign ram_wdata = ctl.alloc_wr ? hit_word
                                  : (word_eff & ~(WORD_W'(1) << free_bit));

  // a row never written reads as all free
  assign eff_addr = ctl.free_wr ? free_word : chk_addr;
  assign word_eff = row_valid[eff_addr] ? ram_rdata : '0;

  nfsa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // first pass covers bits at or above the cursor, the final pass bits below it
  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      logic ok;
      ok = 1'b1;
      if ((chk_addr == AW'(NW - 1)) && (b >= LAST_N)) begin
        ok = 1'b0;
      end
      if ((chk_k == KW'(0)) && (BIT_W'(b) < start_off)) begin
        ok = 1'b0;
      end
      if ((chk_k == KW'(NW)) && (BIT_W'(b) >= start_off)) begin
        ok = 1'b0;
      end
      free_bits[b] = ok & ~word_eff[b];
    end
  end

  always_comb begin
    hit_bit = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (free_bits[b]) begin
        hit_bit = BIT_W'(b);
      end
    end
  end

  assign hit_any   = |free_bits;
  assign hit       = ctl.scan && chk_vld && hit_any;
  assign hit_idx_x = {chk_addr, hit_bit};
  assign hit_idx   = hit_idx_x[IW-1:0];

  assign sts.req_free     = (cmd == CMD_FREE);
  assign sts.req_in_range = in_range;
  assign sts.hit          = hit;
  assign sts.exhausted    = ctl.scan && chk_vld && !hit_any && (chk_k == KW'(NW));
  assign sts.out_free     = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      req_idx    <= slot_index[IW-1:0];
      start_off  <= cursor_x[BIT_W-1:0];
      rd_addr    <= cursor_x[XW-1:BIT_W];
      iss_k      <= '0;
      res_grant  <= '0;
      if (cmd == CMD_FREE) begin
        res_status <= in_range ? ST_OK : ST_RANGE;
      end else begin
        res_status <= ST_FULL;
      end
    end
    if (issue_en) begin
      rd_addr <= (rd_addr == AW'(NW - 1)) ? '0 : rd_addr + AW'(1);
      iss_k   <= iss_k + KW'(1);
    end
    if (ctl.scan) begin
      chk_addr <= rd_addr;
      chk_k    <= iss_k;
    end
    if (hit) begin
      hit_addr   <= chk_addr;
      hit_word   <= word_eff | (WORD_W'(1) << hit_bit);
      found_idx  <= hit_idx;
      res_status <= ST_OK;
      res_grant  <= GRANTW'(hit_idx);
    end
    if (ctl.load_out) begin
      status       <= res_status;
      granted_slot <= res_grant;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chk_vld   <= 1'b0;
      row_valid <= '0;
      cursor    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.accept) begin
        chk_vld <= 1'b0;
      end else if (ctl.scan) begin
        chk_vld <= issue_en;
      end
      if (ram_we) begin
        row_valid[ram_waddr] <= 1'b1;
      end
      if (ctl.alloc_wr) begin
        cursor <= (found_idx == IW'(SLOTS - 1)) ? '0 : found_idx + IW'(1);
      end
      if (ctl.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/nfsa_chk.sv
module nfsa_chk
  import nfsa_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              cmd,
  input logic [IDXW-1:0]   slot_index,
  input logic              out_valid,
  input logic              out_ready,
  input logic [STATW-1:0]  status,
  input logic [GRANTW-1:0] granted_slot
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(granted_slot))
    else $error("result changed while stalled");

  // one transaction in work at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted back to back");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK) || (status == ST_FULL) || (status == ST_RANGE))
    else $error("unknown status code");

  a_grant_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> granted_slot == '0)
    else $error("slot given with failing status");

endmodule

bind next_fit_slot_allocator nfsa_chk u_nfsa_chk (.*);
